FILE: rtl/core/rtq_pkg.sv
// Shared types and constants for the repeating timer queue.
// No dependencies; imported by every module of the core.
`default_nettype none
package rtq_pkg;
    localparam int MAX_TIMERS = 16;
    localparam int SLOT_W     = $clog2(MAX_TIMERS);
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int RANK_W     = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_POLL   = 2'd1,
        OP_REPORT = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_FIRED   = 3'd1,
        ST_ADDED   = 3'd2,
        ST_RETIRED = 3'd3,
        ST_REARMED = 3'd4,
        ST_FULL    = 3'd5,
        ST_SEQERR  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_ADD,
        FSM_RANK,
        FSM_UPDATE,
        FSM_DONE
    } fsm_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;      // capture the command fields
        logic       scan_clr;  // reset scan index and best
        logic       scan_step; // examine one slot
        logic       add_wr;    // write captured timer into free slot
        logic       rank_step; // close rank gap for one slot
        logic       upd_wr;    // rearm or retire pending slot
        logic       set_last;  // store poll time
        logic       fire;      // mark best as pending
        status_t    status;
        logic       emit;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic       scan_last;
        logic       has_free;
        logic       has_best;
        logic       pending;
        opcode_t    op;
        logic       op_bad;
        logic       rearm;
    } sts_t;

    localparam logic [31:0] REPEAT_FOREVER = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

FILE: rtl/core/rtq_datapath.sv
// Timer table, scan unit and update logic of the timer queue.
// Depends on rtq_pkg; sequenced by rtq_control.
`default_nettype none
module rtq_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rtq_pkg::ctl_t    ctl,
    output rtq_pkg::sts_t         sts,
    input  wire logic [1:0]       opcode,
    input  wire logic [31:0]      expiry_time,
    input  wire logic [31:0]      repeat_interval,
    input  wire logic [31:0]      repeat_count,
    input  wire logic [7:0]       timer_tag,
    input  wire logic [31:0]      now_time,
    input  wire logic signed [31:0] action_result,
    output logic                  strobe,
    output logic [2:0]            status,
    output logic [7:0]            fired_tag,
    output logic [31:0]           fire_time,
    output logic [4:0]            live_timers
);
    import rtq_pkg::*;

    logic [31:0]       exp_mem [MAX_TIMERS];
    logic [31:0]       ivl_mem [MAX_TIMERS];
    logic [31:0]       rep_mem [MAX_TIMERS];
    logic [7:0]        tag_mem [MAX_TIMERS];
    logic [RANK_W-1:0] rank_mem [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] valid_reg;

    logic [1:0]  op_reg;
    logic [31:0] a_reg, b_reg, c_reg;
    logic [7:0]  t_reg;
    logic [31:0] last_reg;
    logic        pend_reg;
    logic [SLOT_W-1:0] pslot_reg;
    logic [CNT_W-1:0]  live_reg;
    logic [CNT_W-1:0]  live_next;

    logic [CNT_W-1:0]  idx_reg;
    logic [SLOT_W-1:0] best_reg, free_reg;
    logic              has_best_reg, has_free_reg;
    logic [31:0]       best_exp_reg;
    logic [RANK_W-1:0] best_rank_reg;

    logic [SLOT_W-1:0] si;
    logic [31:0]       cnt_new;
    logic              neg;
    logic [31:0]       ivl_new;

    assign si = idx_reg[SLOT_W-1:0];
    assign neg = a_reg[31];

    always_comb
    begin
        cnt_new = rep_mem[pslot_reg];
        ivl_new = ivl_mem[pslot_reg];
        if (neg)
            cnt_new = '0;
        else if (a_reg != '0)
            ivl_new = a_reg;
        else if (cnt_new != REPEAT_FOREVER && cnt_new != '0)
            cnt_new = cnt_new - 32'd1;
    end

    // count after this command, so the reported figure includes its effect
    always_comb
    begin
        live_next = live_reg;
        if (ctl.add_wr)
            live_next = live_reg + CNT_W'(1);
        else if (ctl.upd_wr && cnt_new == '0)
            live_next = live_reg - CNT_W'(1);
    end

    always_comb
    begin
        sts.scan_last = (idx_reg == CNT_W'(MAX_TIMERS - 1));
        sts.has_free  = has_free_reg;
        sts.has_best  = has_best_reg;
        sts.pending   = pend_reg;
        sts.op_bad    = (op_reg == 2'd3);
        sts.op        = opcode_t'(op_reg);
        sts.rearm     = (cnt_new != '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg <= (opcode == OP_POLL) ? now_time :
                     (opcode == OP_REPORT) ? action_result : expiry_time;
            b_reg <= repeat_interval;
            c_reg <= repeat_count;
            t_reg <= timer_tag;
        end
        if (ctl.add_wr)
        begin
            exp_mem[free_reg]  <= (a_reg != '0) ? a_reg : last_reg + b_reg;
            ivl_mem[free_reg]  <= b_reg;
            rep_mem[free_reg]  <= c_reg;
            tag_mem[free_reg]  <= t_reg;
            rank_mem[free_reg] <= RANK_W'(live_reg);
        end
        if (ctl.rank_step && valid_reg[si] && si != pslot_reg
            && rank_mem[si] > rank_mem[pslot_reg])
            rank_mem[si] <= rank_mem[si] - 1'b1;
        if (ctl.upd_wr)
        begin
            rep_mem[pslot_reg] <= cnt_new;
            ivl_mem[pslot_reg] <= ivl_new;
            if (cnt_new != '0)
            begin
                exp_mem[pslot_reg]  <= exp_mem[pslot_reg] + ivl_new;
                rank_mem[pslot_reg] <= RANK_W'(live_reg - 1'b1);
            end
        end
        if (ctl.scan_clr)
            best_exp_reg <= '0;
        if (ctl.scan_step && valid_reg[si] && exp_mem[si] <= a_reg &&
            (!has_best_reg || exp_mem[si] < best_exp_reg ||
             (exp_mem[si] == best_exp_reg && rank_mem[si] < best_rank_reg)))
        begin
            best_exp_reg  <= exp_mem[si];
            best_rank_reg <= rank_mem[si];
        end
        if (ctl.emit)
        begin
            status      <= ctl.status;
            fired_tag   <= (ctl.status == ST_FIRED) ? tag_mem[best_reg] : 8'd0;
            fire_time   <= (ctl.status == ST_FIRED) ? a_reg : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= '0; valid_reg <= '0; last_reg <= '0; pend_reg <= 1'b0;
            pslot_reg <= '0; live_reg <= '0; idx_reg <= '0; best_reg <= '0;
            free_reg <= '0; has_best_reg <= 1'b0; has_free_reg <= 1'b0;
            strobe <= 1'b0; live_timers <= '0;
        end
        else
        begin
            strobe <= ctl.emit;
            live_reg <= live_next;
            if (ctl.emit)
                live_timers <= 5'(live_next);
            if (ctl.load)
                op_reg <= opcode;
            if (ctl.scan_clr)
            begin
                idx_reg <= '0; has_best_reg <= 1'b0; has_free_reg <= 1'b0;
            end
            if (ctl.scan_step || ctl.rank_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                // lowest free slot
                if (ctl.scan_step && !valid_reg[si] && !has_free_reg)
                begin
                    has_free_reg <= 1'b1; free_reg <= si;
                end
                if (ctl.scan_step && valid_reg[si] && exp_mem[si] <= a_reg &&
                    (!has_best_reg || exp_mem[si] < best_exp_reg ||
                     (exp_mem[si] == best_exp_reg && rank_mem[si] < best_rank_reg)))
                begin
                    has_best_reg <= 1'b1; best_reg <= si;
                end
            end
            if (ctl.add_wr)
                valid_reg[free_reg] <= 1'b1;
            if (ctl.set_last)
                last_reg <= a_reg;
            if (ctl.fire)
            begin
                pend_reg <= 1'b1; pslot_reg <= best_reg;
            end
            if (ctl.upd_wr)
            begin
                pend_reg <= 1'b0;
                if (cnt_new == '0)
                    valid_reg[pslot_reg] <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/rtq_control.sv
// Sequencer for the timer queue: decodes a command and steps the datapath.
// Depends on rtq_pkg.
`default_nettype none
module rtq_control (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output rtq_pkg::ctl_t      ctl,
    input  wire rtq_pkg::sts_t sts
);
    import rtq_pkg::*;

    fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FSM_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        ctl.status = ST_SEQERR;
        busy = (state_reg != FSM_IDLE);
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    ctl.scan_clr = 1'b1;
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE:
            begin
                // decode the captured command
                if (sts.op_bad || (sts.op == OP_POLL && sts.pending) ||
                    (sts.op == OP_REPORT && !sts.pending))
                begin
                    ctl.emit = 1'b1;
                    state_next = FSM_IDLE;
                end
                else if (sts.op == OP_REPORT)
                    state_next = FSM_RANK;
                else
                    state_next = FSM_SCAN;
            end
            FSM_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = (sts.op == OP_ADD) ? FSM_ADD : FSM_UPDATE;
            end
            FSM_RANK:
            begin
                ctl.rank_step = 1'b1;
                if (sts.scan_last)
                    state_next = FSM_UPDATE;
            end
            FSM_ADD:
            begin
                ctl.emit = 1'b1;
                ctl.add_wr = sts.has_free;
                ctl.status = sts.has_free ? ST_ADDED : ST_FULL;
                state_next = FSM_IDLE;
            end
            FSM_UPDATE:
            begin
                ctl.emit = 1'b1;
                if (sts.op == OP_POLL)
                begin
                    ctl.set_last = 1'b1;
                    ctl.fire = sts.has_best;
                    ctl.status = sts.has_best ? ST_FIRED : ST_IDLE;
                end
                else
                begin
                    ctl.upd_wr = 1'b1;
                    ctl.status = sts.rearm ? ST_REARMED : ST_RETIRED;
                end
                state_next = FSM_IDLE;
            end
            default: state_next = FSM_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/core/repeating_timer_queue_core.sv
// Repeating timer queue: one result per command, strobed for one cycle.
// Error commands are answered from the decode state; add and poll walk the 16-slot scan, report the 16-slot rank pass.
// One command at a time: a new start is taken only while the sequencer is idle and no result is strobing.
// Reset: async active low clears valid bits, pending report, last time and control.
// The receiver cannot stall; each result is strobed for exactly one cycle.
`default_nettype none
module repeating_timer_queue_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic [31:0]        expiry_time,
    input  wire logic [31:0]        repeat_interval,
    input  wire logic [31:0]        repeat_count,
    input  wire logic [7:0]         timer_tag,
    input  wire logic [31:0]        now_time,
    input  wire logic signed [31:0] action_result,
    output logic                    strobe,
    output logic [2:0]              status,
    output logic [7:0]              fired_tag,
    output logic [31:0]             fire_time,
    output logic [4:0]              live_timers
);
    import rtq_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic busy_int;

    // hold off a new transfer while the previous result is on the ports
    rtq_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start && !strobe), .busy(busy_int),
        .ctl(ctl), .sts(sts)
    );

    rtq_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .opcode(opcode), .expiry_time(expiry_time),
        .repeat_interval(repeat_interval), .repeat_count(repeat_count),
        .timer_tag(timer_tag), .now_time(now_time),
        .action_result(action_result), .strobe(strobe), .status(status),
        .fired_tag(fired_tag), .fire_time(fire_time), .live_timers(live_timers)
    );

    // busy also covers the strobe cycle so a result never overlaps a new transfer
    assign busy = busy_int || strobe;

    a_live_max: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> live_timers <= 5'(MAX_TIMERS))
        else $error("live count out of range");
    a_fire_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status != ST_FIRED) |-> (fired_tag == 8'd0 && fire_time == 32'd0))
        else $error("fire fields set without firing");
    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("back to back strobes");
endmodule
`default_nettype wire
